// ----- rtl/seu_pkg.sv -----
// Package for the stack expression unit: command codes, status codes, sizes.
// Used by seu_alu and stack_expression_unit_top; depends on nothing.
package seu_pkg;
	localparam int STACK_WORDS = 64;
	localparam int AW = $clog2(STACK_WORDS);
	localparam int LW = 7;

	typedef enum logic [4:0] {
		CMD_START = 5'd0, CMD_PRESET = 5'd1, CMD_PUSH = 5'd2, CMD_GET = 5'd3,
		CMD_SET = 5'd4, CMD_ADD = 5'd5, CMD_SUB = 5'd6, CMD_MUL = 5'd7,
		CMD_SHL = 5'd8, CMD_SHR = 5'd9, CMD_OR = 5'd10, CMD_AND = 5'd11,
		CMD_EQ = 5'd12, CMD_LT = 5'd13, CMD_GT = 5'd14, CMD_LOR = 5'd15,
		CMD_LAND = 5'd16, CMD_DIV = 5'd17, CMD_CADD = 5'd18, CMD_CSUB = 5'd19,
		CMD_CDIV = 5'd20, CMD_CMUL = 5'd21, CMD_NOT = 5'd22, CMD_SEL = 5'd23
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_SLOT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_ALU, S_TOP, S_OUT
	} state_t;

	typedef struct packed {
		logic [4:0] op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;
endpackage

// ----- rtl/seu_alu.sv -----
// Binary operator unit of the stack expression unit, multi-cycle.
// Iterative dividers for word and colour divide; depends on seu_pkg.
module seu_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  seu_pkg::alu_req_t req,
	output logic              done,
	output logic [31:0]       result
);
	logic              busy_q;
	logic [5:0]        cnt_q;
	seu_pkg::alu_req_t r_q;
	logic [31:0]       quo_q, rem_q;
	logic [7:0]        cq_q [3];
	logic [7:0]        cr_q [3];
	logic [32:0]       rem_sh;
	logic [33:0]       rem_sub;
	logic [31:0]       comb_res;
	logic [8:0]        cr_sh [3];
	logic [8:0]        cr_sub [3];
	logic [15:0]       prod [3];
	logic [8:0]        sum [3];
	logic [31:0]       mprod;
	logic              iter_op;

	assign iter_op = (req.op == seu_pkg::CMD_DIV) || (req.op == seu_pkg::CMD_CDIV);
	assign rem_sh = {rem_q, quo_q[31]};
	assign rem_sub = {1'b0, rem_sh} - {2'b0, r_q.b};
	assign mprod = r_q.a * r_q.b;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr_sh[i] = {cr_q[i], cq_q[i][7]};
			cr_sub[i] = cr_sh[i] - {1'b0, r_q.b[8*i +: 8]};
			sum[i] = {1'b0, r_q.a[8*i +: 8]} + {1'b0, r_q.b[8*i +: 8]};
			prod[i] = r_q.a[8*i +: 8] * r_q.b[8*i +: 8];
		end
	end

	always_comb begin
		comb_res = '0;
		unique case (r_q.op)
			seu_pkg::CMD_ADD:  comb_res = r_q.a + r_q.b;
			seu_pkg::CMD_SUB:  comb_res = r_q.a - r_q.b;
			seu_pkg::CMD_MUL:  comb_res = mprod;
			seu_pkg::CMD_SHL:  comb_res = (r_q.b >= 32'd32) ? '0 : r_q.a << r_q.b[4:0];
			seu_pkg::CMD_SHR:  comb_res = (r_q.b >= 32'd32) ? '0 : r_q.a >> r_q.b[4:0];
			seu_pkg::CMD_OR:   comb_res = r_q.a | r_q.b;
			seu_pkg::CMD_AND:  comb_res = r_q.a & r_q.b;
			seu_pkg::CMD_EQ:   comb_res = {31'd0, r_q.a == r_q.b};
			seu_pkg::CMD_LT:   comb_res = {31'd0, r_q.a < r_q.b};
			seu_pkg::CMD_GT:   comb_res = {31'd0, r_q.a > r_q.b};
			seu_pkg::CMD_LOR:  comb_res = {31'd0, (r_q.a != 0) || (r_q.b != 0)};
			seu_pkg::CMD_LAND: comb_res = {31'd0, (r_q.a != 0) && (r_q.b != 0)};
			seu_pkg::CMD_DIV:  comb_res = (r_q.b == 0) ? '1 : quo_q;
			seu_pkg::CMD_CADD:
				for (int i = 0; i < 3; i++)
					comb_res[8*i +: 8] = sum[i][8] ? 8'hFF : sum[i][7:0];
			seu_pkg::CMD_CSUB:
				for (int i = 0; i < 3; i++)
					comb_res[8*i +: 8] = (r_q.a[8*i +: 8] > r_q.b[8*i +: 8]) ?
						r_q.a[8*i +: 8] - r_q.b[8*i +: 8] : 8'd0;
			seu_pkg::CMD_CDIV:
				for (int i = 0; i < 3; i++)
					comb_res[8*i +: 8] = (r_q.b[8*i +: 8] == 0) ? 8'hFF : cq_q[i];
			default:
				for (int i = 0; i < 3; i++)
					comb_res[8*i +: 8] = (prod[i][15:8] != 0) ? 8'hFF : prod[i][7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= iter_op ? ((req.op == seu_pkg::CMD_DIV) ? 6'd32 : 6'd8) : 6'd0;
			end else if (busy_q) begin
				if (cnt_q == 0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= req;
			quo_q <= req.a;
			rem_q <= '0;
			for (int i = 0; i < 3; i++) begin
				cq_q[i] <= req.a[8*i +: 8];
				cr_q[i] <= '0;
			end
		end else if (busy_q && cnt_q != 0) begin
			if (rem_sub[33]) begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end else begin
				rem_q <= rem_sub[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end
			for (int i = 0; i < 3; i++) begin
				if (cr_sub[i][8]) begin
					cr_q[i] <= cr_sh[i][7:0];
					cq_q[i] <= {cq_q[i][6:0], 1'b0};
				end else begin
					cr_q[i] <= cr_sub[i][7:0];
					cq_q[i] <= {cq_q[i][6:0], 1'b1};
				end
			end
		end
		if (busy_q && cnt_q == 0) result <= comb_res;
	end
endmodule

// ----- rtl/stack_expression_unit_top.sv -----
// Top level of the stack expression unit: sequencer around one stack RAM.
// Uses seu_pkg and seu_alu.
//
// One command at a time. Each command reads the stack RAM over up to three
// reads, executes, writes back and reads the new top; divide and colour
// divide run on the iterative restoring dividers of seu_alu. After reset a
// clearing pass zeroes all 64 words of the RAM before the first command is
// taken. The result waits in an output register.
module stack_expression_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  command,
	input  logic [31:0] literal_value,
	input  logic [7:0]  slot_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] top_value,
	output logic [6:0]  stack_level,
	output logic [1:0]  status
);
	localparam int AW = seu_pkg::AW;
	localparam int LW = seu_pkg::LW;

	logic [31:0] mem [seu_pkg::STACK_WORDS];
	logic [31:0] rd_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	seu_pkg::state_t st_q, st_d;
	logic [1:0]    rcnt_q;
	logic [1:0]    need;
	logic [AW:0]   clr_q;
	logic          clearing;
	logic [4:0]    cmd_q;
	logic [31:0]   lit_q;
	logic [7:0]    slot_q;
	logic [LW-1:0] lv_q, lv_new;
	logic [31:0]   opr_q [3];
	seu_pkg::status_t stat;
	logic          bad;
	logic          alu_start, alu_done;
	logic [31:0]   alu_res;
	seu_pkg::alu_req_t req;
	logic          top_ld_q;
	logic [31:0]   top_hold_q;

	assign clearing = !clr_q[AW];
	assign in_ready = (st_q == seu_pkg::S_IDLE) && !clearing;

	always_comb begin
		stat = seu_pkg::ST_OK;
		lv_new = lv_q;
		need = 2'd0;
		priority case (cmd_q)
			seu_pkg::CMD_START: lv_new = LW'(4);
			seu_pkg::CMD_PRESET: if (slot_q >= 8'(seu_pkg::STACK_WORDS)) stat = seu_pkg::ST_SLOT;
			seu_pkg::CMD_PUSH, seu_pkg::CMD_GET: begin
				if (cmd_q == seu_pkg::CMD_GET && slot_q >= 8'(seu_pkg::STACK_WORDS))
					stat = seu_pkg::ST_SLOT;
				else if ({1'b0, lv_q} + 8'd1 >= 8'(seu_pkg::STACK_WORDS)) stat = seu_pkg::ST_OVER;
				else begin
					lv_new = lv_q + LW'(1);
					need = (cmd_q == seu_pkg::CMD_GET) ? 2'd1 : 2'd0;
				end
			end
			seu_pkg::CMD_SET: begin
				if (slot_q >= 8'(seu_pkg::STACK_WORDS)) stat = seu_pkg::ST_SLOT;
				else if (lv_q < LW'(1)) stat = seu_pkg::ST_UNDER;
				else begin lv_new = lv_q - LW'(1); need = 2'd1; end
			end
			seu_pkg::CMD_NOT: begin
				if (lv_q < LW'(1)) stat = seu_pkg::ST_UNDER;
				else need = 2'd1;
			end
			seu_pkg::CMD_SEL: begin
				if (lv_q < LW'(3)) stat = seu_pkg::ST_UNDER;
				else begin lv_new = lv_q - LW'(2); need = 2'd3; end
			end
			default: begin
				if (cmd_q >= seu_pkg::CMD_ADD && cmd_q <= seu_pkg::CMD_CMUL) begin
					if (lv_q < LW'(2)) stat = seu_pkg::ST_UNDER;
					else begin lv_new = lv_q - LW'(1); need = 2'd2; end
				end
			end
		endcase
	end
	assign bad = (stat != seu_pkg::ST_OK);

	// read address: operand k is at lv-1-k, or the slot for get; the new top in S_ALU and S_TOP
	always_comb begin
		raddr = AW'(lv_q - LW'(1) - LW'(rcnt_q));
		if (cmd_q == seu_pkg::CMD_GET) raddr = slot_q[AW-1:0];
		if (st_q == seu_pkg::S_TOP || st_q == seu_pkg::S_ALU) raddr = AW'(lv_new - LW'(1));
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			seu_pkg::S_IDLE: if (in_valid && in_ready) st_d = seu_pkg::S_READ;
			seu_pkg::S_READ:
				if (bad || rcnt_q == need) st_d = seu_pkg::S_EXEC;
			seu_pkg::S_EXEC:
				st_d = (!bad && need == 2'd2) ? seu_pkg::S_ALU : seu_pkg::S_TOP;
			seu_pkg::S_ALU: if (alu_done) st_d = seu_pkg::S_TOP;
			seu_pkg::S_TOP: st_d = seu_pkg::S_OUT;
			seu_pkg::S_OUT: if (out_ready) st_d = seu_pkg::S_IDLE;
			default: st_d = seu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = AW'(lv_q);
		wdata = '0;
		alu_start = 1'b0;
		req = '{op: cmd_q, a: opr_q[1], b: opr_q[0]};
		if (clearing) begin
			we = 1'b1;
			waddr = clr_q[AW-1:0];
		end else if (st_q == seu_pkg::S_EXEC && !bad) begin
			unique case (cmd_q)
				seu_pkg::CMD_PRESET: begin we = 1'b1; waddr = slot_q[AW-1:0]; wdata = lit_q; end
				seu_pkg::CMD_PUSH: begin we = 1'b1; wdata = lit_q; end
				seu_pkg::CMD_GET: begin we = 1'b1; wdata = opr_q[0]; end
				seu_pkg::CMD_SET: begin we = 1'b1; waddr = slot_q[AW-1:0]; wdata = opr_q[0]; end
				seu_pkg::CMD_NOT: begin
					we = 1'b1; waddr = AW'(lv_q - LW'(1)); wdata = {31'd0, opr_q[0] == 0};
				end
				seu_pkg::CMD_SEL: begin
					we = 1'b1; waddr = AW'(lv_q - LW'(3));
					wdata = (opr_q[0] != 0) ? opr_q[1] : opr_q[2];
				end
				default: alu_start = (need == 2'd2);
			endcase
		end else if (st_q == seu_pkg::S_ALU && alu_done) begin
			we = 1'b1; waddr = AW'(lv_q - LW'(2)); wdata = alu_res;
		end
	end

	seu_alu u_alu (
		.clk(clk), .arst_n(arst_n), .start(alu_start), .req(req),
		.done(alu_done), .result(alu_res)
	);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= seu_pkg::S_IDLE;
			clr_q <= '0;
			rcnt_q <= '0;
			lv_q <= LW'(4);
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (st_q == seu_pkg::S_IDLE) rcnt_q <= '0;
			else if (st_q == seu_pkg::S_READ) rcnt_q <= rcnt_q + 2'd1;
			if (st_q == seu_pkg::S_TOP) lv_q <= lv_new;
			if (st_q == seu_pkg::S_TOP) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			lit_q <= literal_value;
			slot_q <= slot_index;
		end
		// read k is issued while rcnt_q is k; its data lands next cycle and goes to opr_q[k]
		if (st_q == seu_pkg::S_READ && rcnt_q != 0) opr_q[rcnt_q - 2'd1] <= rd_q;
		if (st_q == seu_pkg::S_TOP) begin
			stack_level <= lv_new;
			status <= stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) top_ld_q <= 1'b0;
		else top_ld_q <= (st_q == seu_pkg::S_TOP);
	end
	always_ff @(posedge clk) if (top_ld_q) top_hold_q <= (stack_level == 0) ? '0 : rd_q;
	assign top_value = top_ld_q ? ((stack_level == 0) ? '0 : rd_q) : top_hold_q;
endmodule
